// ===== design/obm_pkg.sv =====
// shared types and constants of the order book matcher
package obm_pkg;

   localparam int CSR_W      = 5;
   localparam int MAX_FILLS  = 16;
   localparam int FILL_CNT_W = 5;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 120;

   // request kinds
   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_MATCH  = 2'd2;
   localparam logic [1:0] KIND_IGNORE = 2'd3;

   // result kinds
   localparam logic [1:0] RK_LOAD  = 2'd0;
   localparam logic [1:0] RK_READ  = 2'd1;
   localparam logic [1:0] RK_FILL  = 2'd2;
   localparam logic [1:0] RK_FINAL = 2'd3;

   // order status
   localparam logic [1:0] ST_NONE    = 2'd0;
   localparam logic [1:0] ST_PART    = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_INVALID = 2'd3;

   // order types, codes above market behave as market
   localparam logic [2:0] OT_EXACT     = 3'd0;
   localparam logic [2:0] OT_EXACT_IOC = 3'd1;
   localparam logic [2:0] OT_IOC       = 3'd2;
   localparam logic [2:0] OT_LIMIT     = 3'd3;
   localparam logic [2:0] OT_MARKET    = 3'd4;

   localparam logic SIDE_BUY = 1'b0;

   typedef struct packed {
      logic [15:0] symbol;
      logic [31:0] price;
      logic [31:0] quantity;
      logic [1:0]  status;
   } entry_type;

   typedef struct packed {
      logic [15:0] symbol;
      logic [31:0] price;
      logic [31:0] quantity;
      logic [1:0]  status;
      logic        side;
      logic [2:0]  match_rule;
   } incoming_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] entry_quantity;
      logic [1:0]  entry_status;
      logic [31:0] incoming_quantity;
      logic [1:0]  incoming_status;
   } fill_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  index;
      entry_type   entry;
      logic [31:0] incoming_quantity;
      logic [1:0]  incoming_status;
      logic        last;
   } result_type;

endpackage

// ===== design/obm_ram.sv =====
// generic single-port-write ram with registered read
module obm_ram #(
   parameter int WIDTH = 82,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/obm_fill_unit.sv =====
// shared price compare and quantity subtract unit for one book entry
module obm_fill_unit (
   input  obm_pkg::entry_type    entry,
   input  obm_pkg::incoming_type incoming,
   output obm_pkg::fill_type     fill
);

   logic        live;
   logic        price_lt;
   logic        price_eq;
   logic        price_ok;
   logic [32:0] book_minus_inc;
   logic [31:0] inc_minus_book;

   assign live = ((entry.status == obm_pkg::ST_NONE) || (entry.status == obm_pkg::ST_PART))
              && (entry.symbol == incoming.symbol);
   assign price_lt = entry.price < incoming.price;
   assign price_eq = entry.price == incoming.price;
   assign book_minus_inc = {1'b0, entry.quantity} - {1'b0, incoming.quantity};
   assign inc_minus_book = incoming.quantity - entry.quantity;

   always_comb begin
      case (incoming.match_rule) inside
         obm_pkg::OT_EXACT, obm_pkg::OT_EXACT_IOC: price_ok = price_eq;
         obm_pkg::OT_IOC, obm_pkg::OT_LIMIT: begin
            // buy crosses at or below its price, sell at or above
            price_ok = (incoming.side == obm_pkg::SIDE_BUY) ? (price_lt | price_eq) : !price_lt;
         end
         default: price_ok = 1'b1;
      endcase
   end

   always_comb begin
      fill.hit = live & price_ok;
      if (!book_minus_inc[32]) begin
         // incoming fully filled by this entry
         fill.entry_quantity    = book_minus_inc[31:0];
         fill.entry_status      = (book_minus_inc[31:0] == 32'd0) ? obm_pkg::ST_FULL
                                                                   : obm_pkg::ST_PART;
         fill.incoming_quantity = 32'd0;
         fill.incoming_status   = obm_pkg::ST_FULL;
      end else begin
         fill.entry_quantity    = 32'd0;
         fill.entry_status      = obm_pkg::ST_FULL;
         fill.incoming_quantity = inc_minus_book;
         fill.incoming_status   = obm_pkg::ST_PART;
      end
   end

endmodule

// ===== design/order_book_matcher.sv =====
// order book matcher top level: request sequencer, book ram and shared fill unit
// load: result valid in the cycle after accept; read: passes through S_READ (book ram registered read)
// match: scans book entries in S_SCAN, sends each fill through S_RESP, then the final result
// one request at a time; the next is taken in the cycle after the last result is accepted.
// reset clears the sequencer and book_entries; book contents are not cleared
module order_book_matcher #(
   parameter int BOOK_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // entry_index, symbol_id, price, quantity, status, side, match_rule, zero pad
   input  logic [obm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // kind
   input  logic [1:0]                      req_tuser,
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // book_index, entry_symbol, entry_price, entry_quantity, entry_status,
   // incoming_quantity, incoming_status
   output logic [obm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // result_kind
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast,
   // book_entries register write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [obm_pkg::CSR_W-1:0]       csr_data
);

   localparam int AW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
   localparam int CW = $clog2(BOOK_DEPTH + 1);
   localparam int LW = (CW > obm_pkg::CSR_W) ? CW : obm_pkg::CSR_W;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_SCAN  = 5'b00100,
      S_FINAL = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type                   state_ff, state_in;
   state_type                   after_ff, after_in;      // where to go once the result is taken
   logic [obm_pkg::CSR_W-1:0]   entries_ff, entries_in;
   obm_pkg::incoming_type       inc_ff, inc_in;
   logic [3:0]                  idx_ff, idx_in;
   logic [CW-1:0]               scan_idx_ff, scan_idx_in;
   logic [obm_pkg::FILL_CNT_W-1:0] fills_ff, fills_in;
   obm_pkg::result_type         res_ff, res_in;

   logic                        req_acc;
   logic [3:0]                  req_idx;
   obm_pkg::incoming_type       req_inc;
   logic                        req_idx_ok;
   logic                        idx_ok;
   logic [LW-1:0]               entries_ext;
   logic [LW-1:0]               depth_ext;
   logic [CW-1:0]               scan_len;
   logic [CW-1:0]               scan_next;
   logic                        inc_is_ioc;

   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   obm_pkg::entry_type          wr_data;
   logic [AW-1:0]               rd_addr;
   obm_pkg::entry_type          rd_entry;
   obm_pkg::fill_type           fill;

   // request unpacking
   assign req_acc            = req_tvalid & req_tready;
   assign req_idx            = req_tdata[3:0];
   assign req_inc.symbol     = req_tdata[19:4];
   assign req_inc.price      = req_tdata[51:20];
   assign req_inc.quantity   = req_tdata[83:52];
   assign req_inc.status     = req_tdata[85:84];
   assign req_inc.side       = req_tdata[86];
   assign req_inc.match_rule = req_tdata[89:87];

   // entries beyond the book depth are neither stored nor read
   assign req_idx_ok = 32'(req_idx) < BOOK_DEPTH;
   assign idx_ok     = 32'(idx_ff) < BOOK_DEPTH;

   // scanned prefix, saturated at the book depth
   assign entries_ext = LW'(entries_ff);
   assign depth_ext   = LW'(BOOK_DEPTH);
   assign scan_len    = (entries_ext > depth_ext) ? CW'(depth_ext) : CW'(entries_ext);
   assign scan_next   = scan_idx_ff + 1'b1;

   assign inc_is_ioc = (inc_ff.match_rule == obm_pkg::OT_EXACT_IOC)
                    || (inc_ff.match_rule == obm_pkg::OT_IOC);

   // config register, written only while idle
   assign csr_ready  = state_ff == S_IDLE;
   assign entries_in = (csr_valid & csr_ready) ? csr_data : entries_ff;

   obm_ram #(
      .WIDTH ($bits(obm_pkg::entry_type)),
      .DEPTH (BOOK_DEPTH)
   ) u_book (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   obm_fill_unit u_fill (
      .entry    (rd_entry),
      .incoming (inc_ff),
      .fill     (fill)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      after_in    = after_ff;
      inc_in      = inc_ff;
      idx_in      = idx_ff;
      scan_idx_in = scan_idx_ff;
      fills_in    = fills_ff;
      res_in      = res_ff;
      rd_addr     = AW'(scan_idx_ff);
      wr_en       = 1'b0;
      wr_addr     = AW'(scan_idx_ff);
      wr_data     = rd_entry;

      unique case (state_ff)
         S_IDLE: begin
            // a read looks up its entry, a match starts at entry zero
            rd_addr = (req_tuser == obm_pkg::KIND_READ) ? AW'(req_idx) : '0;
            if (req_acc) begin
               idx_in      = req_idx;
               inc_in      = req_inc;
               scan_idx_in = '0;
               fills_in    = '0;
               unique case (req_tuser)
                  obm_pkg::KIND_LOAD: begin
                     wr_en            = req_idx_ok;
                     wr_addr          = AW'(req_idx);
                     wr_data.symbol   = req_inc.symbol;
                     wr_data.price    = req_inc.price;
                     wr_data.quantity = req_inc.quantity;
                     wr_data.status   = req_inc.status;
                     res_in           = '0;
                     res_in.kind      = obm_pkg::RK_LOAD;
                     res_in.index     = req_idx;
                     res_in.last      = 1'b1;
                     state_in         = S_RESP;
                     after_in         = S_IDLE;
                  end
                  obm_pkg::KIND_READ: begin
                     state_in = S_READ;
                  end
                  obm_pkg::KIND_MATCH: begin
                     // empty book or finished incoming order: final state only
                     if ((scan_len == '0) || (req_inc.status == obm_pkg::ST_FULL)
                         || (req_inc.status == obm_pkg::ST_INVALID)) begin
                        state_in = S_FINAL;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     // ignored kind, no result
                  end
               endcase
            end
         end
         S_READ: begin
            res_in       = '0;
            res_in.kind  = obm_pkg::RK_READ;
            res_in.index = idx_ff;
            if (idx_ok) begin
               res_in.entry = rd_entry;
            end
            res_in.last  = 1'b1;
            state_in     = S_RESP;
            after_in     = S_IDLE;
         end
         S_SCAN: begin
            // fetch the next entry while this one is checked
            rd_addr = AW'(scan_next);
            if (fill.hit) begin
               wr_en                    = 1'b1;
               wr_data.quantity         = fill.entry_quantity;
               wr_data.status           = fill.entry_status;
               inc_in.quantity          = fill.incoming_quantity;
               inc_in.status            = fill.incoming_status;
               res_in.kind              = obm_pkg::RK_FILL;
               res_in.index             = 4'(scan_idx_ff);
               res_in.entry             = wr_data;
               res_in.incoming_quantity = fill.incoming_quantity;
               res_in.incoming_status   = fill.incoming_status;
               res_in.last              = 1'b0;
               fills_in                 = fills_ff + 1'b1;
               scan_idx_in              = scan_next;
               state_in                 = S_RESP;
               // earlier entries stay unmatchable, so the scan resumes past this one
               if ((fill.incoming_status == obm_pkg::ST_FULL)
                   || (fills_in == obm_pkg::FILL_CNT_W'(obm_pkg::MAX_FILLS))) begin
                  after_in = S_FINAL;
               end else if (scan_next >= scan_len) begin
                  after_in = S_FINAL;
                  if (inc_is_ioc) begin
                     inc_in.status = obm_pkg::ST_INVALID;
                  end
               end else begin
                  after_in = S_SCAN;
               end
            end else if (scan_next >= scan_len) begin
               state_in = S_FINAL;
               if (inc_is_ioc) begin
                  inc_in.status = obm_pkg::ST_INVALID;
               end
            end else begin
               scan_idx_in = scan_next;
            end
         end
         S_FINAL: begin
            res_in                   = '0;
            res_in.kind              = obm_pkg::RK_FINAL;
            res_in.incoming_quantity = inc_ff.quantity;
            res_in.incoming_status   = inc_ff.status;
            res_in.last              = 1'b1;
            state_in                 = S_RESP;
            after_in                 = S_IDLE;
         end
         S_RESP: begin
            // rd_addr holds the next scan entry so its data is ready on return
            if (rsp_tready) begin
               state_in = after_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         after_ff    <= S_IDLE;
         entries_ff  <= '0;
         scan_idx_ff <= '0;
         fills_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         after_ff    <= after_in;
         entries_ff  <= entries_in;
         scan_idx_ff <= scan_idx_in;
         fills_ff    <= fills_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      inc_ff <= inc_in;
      idx_ff <= idx_in;
      res_ff <= res_in;
   end

   // result port
   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = state_ff == S_RESP;
   assign rsp_tuser  = res_ff.kind;
   assign rsp_tlast  = res_ff.last;
   assign rsp_tdata  = {res_ff.incoming_status, res_ff.incoming_quantity,
                        res_ff.entry.status, res_ff.entry.quantity,
                        res_ff.entry.price, res_ff.entry.symbol, res_ff.index};

`ifndef ASSERT_OFF
   a_idle_no_result: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("request taken while a result is pending");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fills_ff <= obm_pkg::FILL_CNT_W'(obm_pkg::MAX_FILLS))
      else $error("fill count beyond limit");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("not idle after last result");

   a_fill_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == obm_pkg::RK_FILL) |-> !rsp_tlast)
      else $error("fill result marked last");
`endif

endmodule
